// ===== rtl/tpc_pkg.sv =====
package tpc_pkg;

   // Record status codes
   localparam logic [1:0] STATUS_VALID = 2'd0;
   localparam logic [1:0] STATUS_DISQ  = 2'd1;

   // Record origin codes
   localparam logic [1:0] ORIGIN_EMBEDDED  = 2'd0;
   localparam logic [1:0] ORIGIN_HANDSHAKE = 2'd1;
   localparam logic [1:0] ORIGIN_STAPLED   = 2'd2;

   // Item kinds carried in tuser
   localparam logic MODE_DEPENDENT = 1'b0;
   localparam logic MODE_RECORD    = 1'b1;

   // Verdict codes
   localparam logic [1:0] VERDICT_COMPLIANT  = 2'd0;
   localparam logic [1:0] VERDICT_NOT_ENOUGH = 2'd1;
   localparam logic [1:0] VERDICT_NOT_DIVERSE = 2'd2;
   localparam logic [1:0] VERDICT_OVERFLOW   = 2'd3;

   // Count kinds walked during evaluation
   localparam logic [1:0] KIND_OPERATOR = 2'd0;
   localparam logic [1:0] KIND_VALID_LOG = 2'd1;
   localparam logic [1:0] KIND_EMBEDDED_LOG = 2'd2;

   // Packed record metadata: status, origin, operator, log
   localparam int META_W = 28;
   typedef struct packed {
      logic [7:0]  log_index;
      logic [15:0] operator_id;
      logic [1:0]  origin;
      logic [1:0]  status;
   } meta_type;

   // Reciprocal of twelve, scaled by 2**13, exact for sums up to 264
   localparam logic [18:0] RECIP_TWELVE = 19'd683;
   localparam logic [8:0]  MONTH_BIAS   = 9'd9;
   localparam logic [63:0] TIME_NONE    = '1;

endpackage

// ===== rtl/tpc_ram.sv =====
module tpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/transparency_policy_checker_core.sv =====
// Certificate transparency policy checker. Load one certificate's dependent
// operator ids (tuser 0) and timestamp records (tuser 1) one item per cycle;
// the item with tlast is loaded too and then starts the evaluation, during
// which req_tready is low. For R stored records and D dependent ids, a
// single sequencer walks the record and dependent-id memories through one
// registered read port each and one key comparator, pairwise for the
// distinct counts. Items past a full store are dropped and give verdict 3.
// One result item follows each tlast item; it waits in an output register.
module transparency_policy_checker_core import tpc_pkg::*; #(
   parameter int MAX_RECORDS   = 16,
   parameter int MAX_DEPENDENT = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // sct_status[1:0], sct_origin[3:2], operator_id[19:4], log_index[27:20],
   // sct_time[91:28], disqualify_time[155:92], lifetime_months[163:156]
   input  logic [167:0] req_tdata,
   // mode[0]
   input  logic         req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // compliance[1:0], operator_count[6:2], valid_log_count[11:7],
   // embedded_log_count[16:12], required_count[21:17], issuance_time[85:22]
   output logic [87:0]  rsp_tdata
);

   localparam int AW  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CW  = $clog2(MAX_RECORDS + 1);
   localparam int DAW = (MAX_DEPENDENT > 1) ? $clog2(MAX_DEPENDENT) : 1;
   localparam int DCW = $clog2(MAX_DEPENDENT + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_QRD  = 4'd1;
   localparam logic [3:0] S_QEV  = 4'd2;
   localparam logic [3:0] S_DRD  = 4'd3;
   localparam logic [3:0] S_DCMP = 4'd4;
   localparam logic [3:0] S_CI   = 4'd5;
   localparam logic [3:0] S_CK   = 4'd6;
   localparam logic [3:0] S_CJ   = 4'd7;
   localparam logic [3:0] S_CC   = 4'd8;
   localparam logic [3:0] S_OUT  = 4'd9;

   // Input fields
   logic [1:0]  in_status;
   logic [1:0]  in_origin;
   logic [15:0] in_oper;
   logic [7:0]  in_log;
   logic [63:0] in_time;
   logic [63:0] in_dq;
   logic [7:0]  in_months;
   meta_type    in_meta;

   assign in_status = req_tdata[1:0];
   assign in_origin = req_tdata[3:2];
   assign in_oper   = req_tdata[19:4];
   assign in_log    = req_tdata[27:20];
   assign in_time   = req_tdata[91:28];
   assign in_dq     = req_tdata[155:92];
   assign in_months = req_tdata[163:156];
   assign in_meta   = '{log_index: in_log, operator_id: in_oper,
                        origin: in_origin, status: in_status};

   // Control and loop state
   logic [3:0]     state_ff, state_in;
   logic [CW-1:0]  rec_cnt_ff, rec_cnt_in;
   logic [DCW-1:0] dep_cnt_ff, dep_cnt_in;
   logic           ovf_ff, ovf_in;
   logic [63:0]    earliest_ff, earliest_in;
   logic [7:0]     months_ff, months_in;
   logic [CW-1:0]  i_ff, i_in;
   logic [CW-1:0]  j_ff, j_in;
   logic [DCW-1:0] k_ff, k_in;
   logic [1:0]     kind_ff, kind_in;
   logic [CW-1:0]  n_ff, n_in;
   logic           seen_ff, seen_in;
   logic           dep_hit_ff, dep_hit_in;
   logic           qual_ff, qual_in;
   logic [15:0]    key_ff, key_in;
   logic [CW-1:0]  ops_ff, ops_in;
   logic [CW-1:0]  vlogs_ff, vlogs_in;
   logic [CW-1:0]  elogs_ff, elogs_in;
   logic           has_emb_ff, has_emb_in;
   logic           has_ne_ff, has_ne_in;
   logic [MAX_RECORDS-1:0] pick_op_ff, pick_op_in;
   logic [MAX_RECORDS-1:0] pick_vl_ff, pick_vl_in;
   logic [MAX_RECORDS-1:0] pick_el_ff, pick_el_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [87:0]    rsp_data_ff, rsp_data_in;

   // Memory ports
   logic            rec_wr;
   logic [AW-1:0]   rec_raddr;
   logic [META_W-1:0] meta_rd;
   logic [63:0]     time_rd;
   logic [63:0]     dq_rd;
   logic            dep_wr;
   logic [DAW-1:0]  dep_raddr;
   logic [15:0]     dep_rd;
   meta_type        rd_meta;
   logic            accept;

   assign accept  = req_tvalid && req_tready;
   assign rec_wr  = accept && (req_tuser == MODE_RECORD) &&
                    (rec_cnt_ff < CW'(MAX_RECORDS));
   assign dep_wr  = accept && (req_tuser == MODE_DEPENDENT) &&
                    (dep_cnt_ff < DCW'(MAX_DEPENDENT));
   assign rd_meta = meta_type'(meta_rd);

   tpc_ram #(.WIDTH(META_W), .DEPTH(MAX_RECORDS)) u_meta_ram (
      .clock(clock), .wr_en(rec_wr), .wr_addr(rec_cnt_ff[AW-1:0]),
      .wr_data(META_W'(in_meta)), .rd_addr(rec_raddr), .rd_data(meta_rd));

   tpc_ram #(.WIDTH(64), .DEPTH(MAX_RECORDS)) u_time_ram (
      .clock(clock), .wr_en(rec_wr), .wr_addr(rec_cnt_ff[AW-1:0]),
      .wr_data(in_time), .rd_addr(rec_raddr), .rd_data(time_rd));

   tpc_ram #(.WIDTH(64), .DEPTH(MAX_RECORDS)) u_dq_ram (
      .clock(clock), .wr_en(rec_wr), .wr_addr(rec_cnt_ff[AW-1:0]),
      .wr_data(in_dq), .rd_addr(rec_raddr), .rd_data(dq_rd));

   tpc_ram #(.WIDTH(16), .DEPTH(MAX_DEPENDENT)) u_dep_ram (
      .clock(clock), .wr_en(dep_wr), .wr_addr(dep_cnt_ff[DAW-1:0]),
      .wr_data(in_oper), .rd_addr(dep_raddr), .rd_data(dep_rd));

   // Shared key comparator and pick selection
   logic [MAX_RECORDS-1:0] pick_sel;
   logic [15:0] rd_key;
   logic        key_eq;

   always_comb begin
      case (kind_ff)
         KIND_OPERATOR:  pick_sel = pick_op_ff;
         KIND_VALID_LOG: pick_sel = pick_vl_ff;
         default:        pick_sel = pick_el_ff;
      endcase
   end

   assign rd_key = (kind_ff == KIND_OPERATOR) ? rd_meta.operator_id
                                               : {8'd0, rd_meta.log_index};
   assign key_eq = (rd_key == key_ff);

   // Required embedded logs and saturated counts
   logic [18:0] req_prod;
   logic [4:0]  req_count;
   logic [6:0]  ops_x, vlogs_x, elogs_x;
   logic [4:0]  ops_s, vlogs_s, elogs_s;
   logic        ne_ok, emb_ok;
   logic [1:0]  verdict;

   assign req_prod  = 19'({1'b0, months_ff} + MONTH_BIAS) * RECIP_TWELVE;
   assign req_count = 5'd1 + 5'(req_prod[18:13]);
   assign ops_x   = 7'(ops_ff);
   assign vlogs_x = 7'(vlogs_ff);
   assign elogs_x = 7'(elogs_ff);
   assign ops_s   = (ops_x > 7'd31) ? 5'd31 : ops_x[4:0];
   assign vlogs_s = (vlogs_x > 7'd31) ? 5'd31 : vlogs_x[4:0];
   assign elogs_s = (elogs_x > 7'd31) ? 5'd31 : elogs_x[4:0];
   assign ne_ok   = has_ne_ff && (vlogs_x >= 7'd2);
   assign emb_ok  = has_emb_ff && (elogs_x >= 7'(req_count));

   always_comb begin
      if (ovf_ff) begin
         verdict = VERDICT_OVERFLOW;
      end else if (ne_ok || emb_ok) begin
         verdict = (ops_x >= 7'd2) ? VERDICT_COMPLIANT : VERDICT_NOT_DIVERSE;
      end else begin
         verdict = VERDICT_NOT_ENOUGH;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      rec_cnt_in  = rec_cnt_ff;
      dep_cnt_in  = dep_cnt_ff;
      ovf_in      = ovf_ff;
      earliest_in = earliest_ff;
      months_in   = months_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      kind_in     = kind_ff;
      n_in        = n_ff;
      seen_in     = seen_ff;
      dep_hit_in  = dep_hit_ff;
      qual_in     = qual_ff;
      key_in      = key_ff;
      ops_in      = ops_ff;
      vlogs_in    = vlogs_ff;
      elogs_in    = elogs_ff;
      has_emb_in  = has_emb_ff;
      has_ne_in   = has_ne_ff;
      pick_op_in  = pick_op_ff;
      pick_vl_in  = pick_vl_ff;
      pick_el_in  = pick_el_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rec_raddr   = i_ff[AW-1:0];
      dep_raddr   = k_ff[DAW-1:0];

      case (state_ff)
         // Load items into the stores
         S_IDLE: begin
            if (accept) begin
               if (req_tuser == MODE_RECORD) begin
                  if (rec_wr) begin
                     rec_cnt_in = rec_cnt_ff + CW'(1);
                     if (in_status == STATUS_VALID && in_time < earliest_ff) begin
                        earliest_in = in_time;
                     end
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  if (dep_wr) begin
                     dep_cnt_in = dep_cnt_ff + DCW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (req_tlast) begin
                  months_in  = in_months;
                  i_in       = '0;
                  has_emb_in = 1'b0;
                  has_ne_in  = 1'b0;
                  state_in   = S_QRD;
               end
            end
         end
         // Read record i for qualification
         S_QRD: begin
            rec_raddr = i_ff[AW-1:0];
            if (i_ff == rec_cnt_ff) begin
               i_in     = '0;
               kind_in  = KIND_OPERATOR;
               n_in     = '0;
               state_in = S_CI;
            end else begin
               state_in = S_QEV;
            end
         end
         // Qualify record i and note its flags
         S_QEV: begin
            qual_in = (rd_meta.status == STATUS_VALID) ||
                      ((rd_meta.status == STATUS_DISQ) && (earliest_ff < dq_rd) &&
                       (time_rd < dq_rd));
            pick_vl_in[i_ff[AW-1:0]] = (rd_meta.status == STATUS_VALID);
            pick_el_in[i_ff[AW-1:0]] = (rd_meta.origin == ORIGIN_EMBEDDED) && qual_in;
            if (rd_meta.status == STATUS_VALID) begin
               if (rd_meta.origin == ORIGIN_EMBEDDED) begin
                  has_emb_in = 1'b1;
               end
               if (rd_meta.origin == ORIGIN_HANDSHAKE || rd_meta.origin == ORIGIN_STAPLED) begin
                  has_ne_in = 1'b1;
               end
            end
            key_in     = rd_meta.operator_id;
            dep_hit_in = 1'b0;
            k_in       = '0;
            state_in   = S_DRD;
         end
         // Read dependent id k
         S_DRD: begin
            dep_raddr = k_ff[DAW-1:0];
            if (k_ff == dep_cnt_ff) begin
               pick_op_in[i_ff[AW-1:0]] = qual_ff && !dep_hit_ff;
               i_in     = i_ff + CW'(1);
               state_in = S_QRD;
            end else begin
               state_in = S_DCMP;
            end
         end
         // Compare dependent id with the record's operator
         S_DCMP: begin
            if (dep_rd == key_ff) begin
               dep_hit_in = 1'b1;
            end
            k_in     = k_ff + DCW'(1);
            state_in = S_DRD;
         end
         // Outer walk of the distinct count
         S_CI: begin
            rec_raddr = i_ff[AW-1:0];
            if (i_ff == rec_cnt_ff) begin
               case (kind_ff)
                  KIND_OPERATOR:  ops_in = n_ff;
                  KIND_VALID_LOG: vlogs_in = n_ff;
                  default:        elogs_in = n_ff;
               endcase
               n_in = '0;
               i_in = '0;
               if (kind_ff == KIND_EMBEDDED_LOG) begin
                  state_in = S_OUT;
               end else begin
                  kind_in = kind_ff + 2'd1;
               end
            end else if (!pick_sel[i_ff[AW-1:0]]) begin
               i_in = i_ff + CW'(1);
            end else begin
               state_in = S_CK;
            end
         end
         // Hold the key of record i
         S_CK: begin
            key_in   = rd_key;
            j_in     = '0;
            seen_in  = 1'b0;
            state_in = S_CJ;
         end
         // Inner walk over earlier records
         S_CJ: begin
            rec_raddr = j_ff[AW-1:0];
            if (j_ff == i_ff) begin
               if (!seen_ff) begin
                  n_in = n_ff + CW'(1);
               end
               i_in     = i_ff + CW'(1);
               state_in = S_CI;
            end else if (!pick_sel[j_ff[AW-1:0]]) begin
               j_in = j_ff + CW'(1);
            end else begin
               state_in = S_CC;
            end
         end
         // Compare key of record j
         S_CC: begin
            if (key_eq) begin
               seen_in = 1'b1;
            end
            j_in     = j_ff + CW'(1);
            state_in = S_CJ;
         end
         // Deliver the verdict and clear for the next certificate
         S_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'd0, earliest_ff, req_count, elogs_s, vlogs_s,
                               ops_s, verdict};
               rec_cnt_in   = '0;
               dep_cnt_in   = '0;
               ovf_in       = 1'b0;
               earliest_in  = TIME_NONE;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rec_cnt_ff   <= '0;
         dep_cnt_ff   <= '0;
         ovf_ff       <= 1'b0;
         earliest_ff  <= TIME_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rec_cnt_ff   <= rec_cnt_in;
         dep_cnt_ff   <= dep_cnt_in;
         ovf_ff       <= ovf_in;
         earliest_ff  <= earliest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      months_ff   <= months_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      kind_ff     <= kind_in;
      n_ff        <= n_in;
      seen_ff     <= seen_in;
      dep_hit_ff  <= dep_hit_in;
      qual_ff     <= qual_in;
      key_ff      <= key_in;
      ops_ff      <= ops_in;
      vlogs_ff    <= vlogs_in;
      elogs_ff    <= elogs_in;
      has_emb_ff  <= has_emb_in;
      has_ne_ff   <= has_ne_in;
      pick_op_ff  <= pick_op_in;
      pick_vl_ff  <= pick_vl_in;
      pick_el_ff  <= pick_el_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Checks
   a_rec_bound: assert property (@(posedge clock) disable iff (reset)
      rec_cnt_ff <= CW'(MAX_RECORDS))
      else $error("record count past store depth");

   a_dep_bound: assert property (@(posedge clock) disable iff (reset)
      dep_cnt_ff <= DCW'(MAX_DEPENDENT))
      else $error("dependent count past store depth");

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("ready during evaluation");

   a_out_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !rsp_valid_ff) |=> (rec_cnt_ff == '0 && rsp_tvalid))
      else $error("result not posted or stores not cleared");

endmodule
